// ===== hdl/dtp_pkg.sv =====
// Package for the decimal text to int64 parser.
// Word types, status codes and character constants; no dependencies.
package dtp_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NULL     = 2'd3
  } dtp_status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
    logic       empty_token;
  } dtp_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    dtp_status_e        status;
  } dtp_out_t;

  // Token state carried between bytes
  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic        at_start;
    logic        digit_seen;
    dtp_status_e err;
  } dtp_state_t;

  localparam logic [63:0] LIMIT_TENTH = 64'd922337203685477580;
  localparam logic [63:0] NULL_VALUE  = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam dtp_state_t STATE_RESET = '{
    acc:        64'd0,
    neg:        1'b0,
    at_start:   1'b1,
    digit_seen: 1'b0,
    err:        ST_OK
  };

endpackage

// ===== hdl/dtp_fold.sv =====
// Combinational byte step: folds one character into the token state.
// Uses dtp_pkg for word, state and status types.
module dtp_fold (
  input  dtp_pkg::dtp_state_t st_i,
  input  dtp_pkg::dtp_in_t    word_i,
  output dtp_pkg::dtp_state_t st_o,
  output logic                res_valid_o,
  output dtp_pkg::dtp_out_t   res_o
);

  logic [7:0]          c;
  logic                is_digit;
  logic                hi_digit;
  logic                ovf;
  logic [63:0]         acc_x10;
  logic [63:0]         acc_next;
  dtp_pkg::dtp_state_t t;

  assign c        = word_i.char_byte;
  assign is_digit = (c >= dtp_pkg::CHAR_ZERO) && (c <= dtp_pkg::CHAR_NINE);
  assign hi_digit = (c > dtp_pkg::CHAR_SEVEN);
  // digits 8 and 9 trip one step earlier
  assign ovf      = hi_digit ? (st_i.acc >= dtp_pkg::LIMIT_TENTH)
                             : (st_i.acc >  dtp_pkg::LIMIT_TENTH);
  assign acc_x10  = {st_i.acc[60:0], 3'b000} + {st_i.acc[62:0], 1'b0};
  assign acc_next = acc_x10 + {60'd0, c[3:0]};

  always_comb begin
    t = st_i;
    if (st_i.err == dtp_pkg::ST_OK) begin
      t.at_start = 1'b0;
      if (st_i.at_start && (c == dtp_pkg::CHAR_MINUS)) begin
        t.neg = 1'b1;
      end else if (st_i.at_start && (c == dtp_pkg::CHAR_PLUS)) begin
        t.neg = st_i.neg;
      end else if (!is_digit) begin
        t.err = dtp_pkg::ST_INVALID;
      end else if (ovf) begin
        t.err = dtp_pkg::ST_OVERFLOW;
      end else begin
        t.acc        = acc_next;
        t.digit_seen = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o.value = 64'sd0;
    res_o.status = dtp_pkg::ST_OK;
    st_o = t;
    if (word_i.empty_token) begin
      res_valid_o  = 1'b1;
      res_o.value  = dtp_pkg::NULL_VALUE;
      res_o.status = dtp_pkg::ST_NULL;
      st_o         = dtp_pkg::STATE_RESET;
    end else if (word_i.last_byte) begin
      res_valid_o = 1'b1;
      st_o        = dtp_pkg::STATE_RESET;
      if (t.err != dtp_pkg::ST_OK) begin
        res_o.status = t.err;
      end else if (!t.digit_seen) begin
        res_o.status = dtp_pkg::ST_INVALID;
      end else begin
        res_o.value = t.neg ? (64'd0 - t.acc) : t.acc;
      end
    end
  end

endmodule

// ===== hdl/dtp_out_reg.sv =====
// Result register with valid/stall handshake toward the consumer.
// Uses dtp_pkg for the result word type.
module dtp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dtp_pkg::dtp_out_t word_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dtp_pkg::dtp_out_t out_word_o
);

  logic              valid_q;
  dtp_pkg::dtp_out_t word_q;

  // slot can take a new word when empty or being drained this cycle
  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      word_q <= word_i;
    end
  end

endmodule

// ===== hdl/decimal_text_to_int64_parser.sv =====
// Decimal text to int64 parser: top level with input register and token state.
// Depends on dtp_pkg, dtp_fold and dtp_out_reg.
//
// Takes a signed decimal token one character word per clock while not stalled
// and returns one 64-bit result word at the token's last character (or at once
// for an empty token). Throughput is one character per clock, sustained, while
// the result register is not both full and stalled. The input register is
// written at the accepting edge. The fold step (multiply-by-ten as shift-add,
// one 64-bit add and the overflow compare) writes the result register from the
// input register once the result register is free, and the result word is held
// there until the consumer takes it. Accepted range is +/-(2^63-1); the most
// negative value reports overflow. Status: ok, invalid literal (non-digit,
// sign alone, sign not first), overflow, or null for an empty token, whose
// value is 0x8000000000000000. Error results carry value zero. After the first
// error the remaining characters of the token are ignored. Input stall rises
// only when the input register holds a word and the result register is full
// and stalled.
module decimal_text_to_int64_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dtp_pkg::dtp_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dtp_pkg::dtp_out_t out_word_o
);

  // Input register
  logic                in_valid_q;
  dtp_pkg::dtp_in_t    in_word_q;

  // Token state
  dtp_pkg::dtp_state_t st_q;
  dtp_pkg::dtp_state_t st_d;

  logic                res_valid;
  dtp_pkg::dtp_out_t   res_word;
  logic                free;
  logic                step;

  // the registered word is consumed whenever the result slot can take it
  assign step       = in_valid_q && free;
  assign in_stall_o = in_valid_q && !free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  dtp_fold u_fold (
    .st_i        (st_q),
    .word_i      (in_word_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dtp_pkg::STATE_RESET;
    end else if (step) begin
      st_q <= st_d;
    end
  end

  dtp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_valid_q && res_valid),
    .word_i      (res_word),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Null results always carry the null value
  a_null_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == dtp_pkg::ST_NULL)
    |-> (out_word_o.value == dtp_pkg::NULL_VALUE))
    else $error("null result with wrong value");

  // Error results carry zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_word_o.status == dtp_pkg::ST_INVALID) ||
                    (out_word_o.status == dtp_pkg::ST_OVERFLOW))
    |-> (out_word_o.value == 64'sd0))
    else $error("error result with nonzero value");

  // Token state returns to reset after a result is produced
  a_token_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_word_q.last_byte || in_word_q.empty_token)
    |=> (st_q == dtp_pkg::STATE_RESET))
    else $error("token state not cleared after result");

  // An error or a folded digit can only follow the first character
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q.err != dtp_pkg::ST_OK) || st_q.digit_seen) |-> !st_q.at_start)
    else $error("token start flag inconsistent");

  // A result word appears only after a consumed word that ends a token
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(step && res_valid))
    else $error("result word without token end");

endmodule

// ===== dv/tb_decimal_text_to_int64_parser.sv =====
// Testbench for decimal_text_to_int64_parser: streams decimal tokens one character
// word at a time, predicts each parsed result and checks it field by field.
// Depends on dtp_pkg and the parser RTL; self-contained otherwise.
`timescale 1ns / 100ps

module tb_decimal_text_to_int64_parser;

  typedef logic [7:0] char_q_t[$];

  // Cycles with no word moving on either side before the run is abandoned.
  // Far above the worst stall run at 85% stall probability.
  localparam int unsigned STUCK_LIMIT = 5000;
  // Drain margin after the last result.
  localparam int unsigned TAIL_CYCLES = 10;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  dtp_pkg::dtp_in_t   in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dtp_pkg::dtp_out_t  out_word_o;

  decimal_text_to_int64_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #1 clk_i = ~clk_i;

  // Idle and stall odds, percent per cycle; changed per test.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned chars_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;

  // Handshake flags, sampled mid-cycle so they are stable; the edge that
  // follows is the one at which the word moves.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  // Results the parser owes us, oldest first.
  dtp_pkg::dtp_out_t parsed_words_q[$];
  dtp_pkg::dtp_out_t want_word;

  // Our own copy of the token state.
  logic [63:0]          tok_mag;
  logic                 tok_neg;
  logic                 tok_first;
  logic                 tok_has_digit;
  dtp_pkg::dtp_status_e tok_err;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic clear_token;
    tok_mag       = '0;
    tok_neg       = 1'b0;
    tok_first     = 1'b1;
    tok_has_digit = 1'b0;
    tok_err       = dtp_pkg::ST_OK;
  endtask

  // Fold one accepted character word into the token state and queue the
  // result it produces, if any.
  task automatic parse_char(input dtp_pkg::dtp_in_t w);
    logic [7:0]        c;
    logic              sign_taken;
    logic              too_big;
    dtp_pkg::dtp_out_t r;
    c          = w.char_byte;
    sign_taken = 1'b0;
    if (w.empty_token) begin
      // Empty token: null result, any partial token is thrown away
      r.value  = dtp_pkg::NULL_VALUE;
      r.status = dtp_pkg::ST_NULL;
      parsed_words_q.push_back(r);
      clear_token();
    end else begin
      // Once an error is latched the rest of the token is ignored
      if (tok_err == dtp_pkg::ST_OK) begin
        if (tok_first) begin
          tok_first = 1'b0;
          if (c == dtp_pkg::CHAR_MINUS) begin
            tok_neg    = 1'b1;
            sign_taken = 1'b1;
          end else if (c == dtp_pkg::CHAR_PLUS) begin
            sign_taken = 1'b1;
          end
        end
        if (!sign_taken) begin
          if (c < dtp_pkg::CHAR_ZERO || c > dtp_pkg::CHAR_NINE) begin
            // non-digit, including a sign that is not first
            tok_err = dtp_pkg::ST_INVALID;
          end else begin
            // Checked before the fold: digits 8 and 9 trip one step earlier,
            // which also rejects the most negative value.
            too_big = (c <= dtp_pkg::CHAR_SEVEN) ? (tok_mag > dtp_pkg::LIMIT_TENTH)
                                                 : (tok_mag >= dtp_pkg::LIMIT_TENTH);
            if (too_big) begin
              tok_err = dtp_pkg::ST_OVERFLOW;
            end else begin
              tok_mag       = tok_mag * 10 + 64'(c - dtp_pkg::CHAR_ZERO);
              tok_has_digit = 1'b1;
            end
          end
        end
      end
      if (w.last_byte) begin
        if (tok_err != dtp_pkg::ST_OK) begin
          r.value  = '0;
          r.status = tok_err;
        end else if (!tok_has_digit) begin
          // a sign alone
          r.value  = '0;
          r.status = dtp_pkg::ST_INVALID;
        end else begin
          r.value  = tok_neg ? (64'd0 - tok_mag) : tok_mag;
          r.status = dtp_pkg::ST_OK;
        end
        parsed_words_q.push_back(r);
        clear_token();
      end
    end
  endtask

  // Receiver: random stall, independent of valid.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Sample both handshakes at the falling edge and check each result word
  // that will be taken at the next rising edge.
  always @(negedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      if (parsed_words_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word value %0d status %0d",
                                  out_word_o.value, out_word_o.status));
      end else begin
        want_word = parsed_words_q.pop_front();
        if (out_word_o.value !== want_word.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    out_word_o.value, want_word.value));
        if (out_word_o.status !== want_word.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_word_o.status, want_word.status));
      end
    end
  end

  // Watchdog: cycles in a row with no word moving on either side.
  always @(posedge clk_i) begin
    if (in_fire || out_fire) stuck_cycles <= 0;
    else                     stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STUCK_LIMIT);
      $display("[decimal_text_to_int64_parser] ERROR");
      $finish;
    end
  end

  // Send one word: random idle first, then hold it until accepted.
  // Called and returns at a rising edge.
  task automatic push_char(input dtp_pkg::dtp_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_fire);
    chars_sent++;
    parse_char(w);
  endtask

  // Characters of a token; last_byte on the final one only when closed.
  task automatic send_token(input char_q_t chars, input logic closed);
    dtp_pkg::dtp_in_t w;
    foreach (chars[i]) begin
      w.char_byte   = chars[i];
      w.last_byte   = closed && (i == chars.size() - 1);
      w.empty_token = 1'b0;
      push_char(w);
    end
  endtask

  task automatic send_text(input string s);
    char_q_t chars;
    for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_token(chars, 1'b1);
  endtask

  task automatic send_empty(input logic [7:0] c, input logic last);
    dtp_pkg::dtp_in_t w;
    w.char_byte   = c;
    w.last_byte   = last;
    w.empty_token = 1'b1;
    push_char(w);
  endtask

  // Sender pause: no new word until every owed result has come back.
  task automatic hold_until_drained;
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (parsed_words_q.size() != 0);
  endtask

  function automatic logic [7:0] random_sign();
    return $urandom_range(0, 1) ? dtp_pkg::CHAR_MINUS : dtp_pkg::CHAR_PLUS;
  endfunction

  // Optional sign, then mostly short digit runs, sometimes long enough to
  // reach the overflow region.
  function automatic char_q_t random_number_text();
    char_q_t t;
    int unsigned n;
    if ($urandom_range(0, 2) != 0) t.push_back(random_sign());
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 6);
    repeat (n) t.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    return t;
  endfunction

  task automatic send_random_token;
    char_q_t     chars;
    logic [63:0] mag;
    string       s;
    int unsigned kind;
    int unsigned pos;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      send_token(random_number_text(), 1'b1);
    end else if (kind < 70) begin
      // Prefix one below, at or one above the tenth of the limit, then a
      // random digit: straddles the 7 vs 8 overflow threshold.
      mag = dtp_pkg::LIMIT_TENTH + 64'($urandom_range(0, 2)) - 64'd1;
      s   = $sformatf("%0d", mag);
      if ($urandom_range(0, 1)) chars.push_back(random_sign());
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      chars.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
        chars.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      send_token(chars, 1'b1);
    end else if (kind < 85) begin
      // Broken literal: a stray byte, or a sign past the first position
      chars = random_number_text();
      if ($urandom_range(0, 1)) begin
        pos        = $urandom_range(0, chars.size() - 1);
        chars[pos] = 8'($urandom_range(0, 255));
      end else begin
        chars.insert($urandom_range(1, chars.size()), random_sign());
      end
      send_token(chars, 1'b1);
    end else if (kind < 93) begin
      if ($urandom_range(0, 2) == 0) begin
        chars.push_back(random_sign());
      end else begin
        repeat ($urandom_range(1, 4)) chars.push_back(8'($urandom_range(0, 255)));
      end
      send_token(chars, 1'b1);
    end else begin
      // Empty token, sometimes cutting off an unfinished one
      if ($urandom_range(0, 1)) send_token(random_number_text(), 1'b0);
      send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_random_tokens(input int unsigned n_chars);
    int unsigned stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_random_token();
  endtask

  // Null, invalid and ok statuses and each corner of the grammar.
  task automatic test_directed;
    char_q_t chars;
    send_idle_pct = 10;
    stall_pct     = 10;
    send_empty(8'hFF, 1'b0);            // null
    send_text("-");                     // sign alone
    send_text("+");
    send_text("0");
    send_text("-9");
    send_text("+7");
    send_text("5-3");                   // sign not first, rest ignored
    chars = {8'h00};
    send_token(chars, 1'b1);
    chars = {8'hFF};
    send_token(chars, 1'b1);
    send_text("12");
    chars = {dtp_pkg::CHAR_ZERO + 8'd1, dtp_pkg::CHAR_ZERO + 8'd2};
    send_token(chars, 1'b0);            // unfinished token ...
    send_empty(8'h00, 1'b1);            // ... dropped by an empty one
    send_text("3");                     // state must be clean again
    send_text("a5");
    send_text("--");
    send_text("/");                     // just below and above the digits
    send_text(":");
    hold_until_drained();
  endtask

  task automatic test_slow_receiver;
    send_idle_pct = 27;
    stall_pct     = 85;
    send_random_tokens(640);
    hold_until_drained();
  endtask

  task automatic test_slow_sender;
    send_idle_pct = 85;
    stall_pct     = 27;
    send_random_tokens(640);
    hold_until_drained();
  endtask

  task automatic test_full_rate;
    send_idle_pct = 0;
    stall_pct     = 0;
    send_random_tokens(640);
    hold_until_drained();
  endtask

  initial begin
    clear_token();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();

    // Everything is back; give a stray extra word time to show up.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[decimal_text_to_int64_parser] OK");
    end else begin
      $display("[decimal_text_to_int64_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dtp_pkg.sv
hdl/dtp_fold.sv
hdl/dtp_out_reg.sv
hdl/decimal_text_to_int64_parser.sv
dv/tb_decimal_text_to_int64_parser.sv
